### rtl/fsr_pkg.sv
package fsr_pkg;

  // Result codes
  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_SESS_DONE = 3'd1,
    ST_OVERRUN = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_DIRECT_DONE = 3'd4,
    ST_READ_DATA = 3'd5
  } status_e;

  // Work class decided by the front end
  typedef enum logic [1:0] {
    KIND_READ = 2'd0,
    KIND_DIRECT = 2'd1,
    KIND_SESSION = 2'd2
  } kind_e;

  localparam int unsigned TagW = 4;

  typedef struct packed {
    logic       req_type;
    logic       direct_mode;
    logic       start_session;
    logic [7:0] session_byte;
    logic [7:0] frag_len;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic [7:0] read_index;
    logic       read_direct;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  read_data;
    logic [31:0] good_count;
    logic [31:0] bad_count;
    logic [31:0] error_count;
    logic [31:0] total_count;
    logic [31:0] notify_count;
  } out_item_t;

  // Classified transaction passed from front end to back end
  typedef struct packed {
    kind_e           kind;
    logic [7:0]      offset;     // byte position inside the fragment
    logic            below_len;  // offset < frag_len
    logic [7:0]      data;
    logic            first;
    logic            last;
    logic            start;
    logic [TagW-1:0] tag;
    logic [7:0]      frag_len;
    logic [7:0]      read_index;
    logic            read_direct;
  } cmd_t;

endpackage

### rtl/fsr_front.sv
module fsr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  fsr_pkg::in_item_t in_item_i,
  input  logic              full_i,
  output logic              push_o,
  output fsr_pkg::cmd_t     cmd_o
);

  logic [7:0] off_q, off_d;
  logic [7:0] off_eff;

  assign push_o  = in_valid_i && !full_i;
  assign off_eff = in_item_i.first_byte ? 8'd0 : off_q;

  always_comb begin
    off_d = off_q;
    if (push_o && !in_item_i.req_type) begin
      off_d = (off_eff == 8'hFF) ? off_eff : off_eff + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= 8'd0;
    end else begin
      off_q <= off_d;
    end
  end

  always_comb begin
    if (in_item_i.req_type) begin
      cmd_o.kind = fsr_pkg::KIND_READ;
    end else if (in_item_i.direct_mode) begin
      cmd_o.kind = fsr_pkg::KIND_DIRECT;
    end else begin
      cmd_o.kind = fsr_pkg::KIND_SESSION;
    end
    cmd_o.offset      = off_eff;
    cmd_o.below_len   = off_eff < in_item_i.frag_len;
    cmd_o.data        = in_item_i.data_byte;
    cmd_o.first       = in_item_i.first_byte;
    cmd_o.last        = in_item_i.last_byte;
    cmd_o.start       = in_item_i.start_session;
    cmd_o.tag         = in_item_i.session_byte[7:4];
    cmd_o.frag_len    = in_item_i.frag_len;
    cmd_o.read_index  = in_item_i.read_index;
    cmd_o.read_direct = in_item_i.read_direct;
  end

endmodule

### rtl/fsr_queue.sv
module fsr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fsr_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output fsr_pkg::cmd_t cmd_o
);

  localparam int unsigned Depth = 2;

  fsr_pkg::cmd_t entry_q [Depth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'(Depth));
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### rtl/fsr_back.sv
module fsr_back #(
  parameter int unsigned RECORD_BYTES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  fsr_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fsr_pkg::out_item_t out_item_o
);

  localparam int unsigned AddrW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam logic [9:0]  RecW  = 10'(RECORD_BYTES);

  logic [7:0] sess_mem [RECORD_BYTES];
  logic [7:0] dir_mem  [RECORD_BYTES];

  logic [9:0]              fill_q, fill_d;
  logic [fsr_pkg::TagW-1:0] tag_q, tag_d;
  logic                    match_q, match_d;
  logic [31:0] good_q, good_d, bad_q, bad_d, err_q, err_d;
  logic [31:0] total_q, total_d, notify_q, notify_d;
  fsr_pkg::status_e status_q, status_d;
  logic out_valid_q;

  logic       we_sess, we_dir;
  logic [9:0] pos, grown, fill_eff;
  logic [fsr_pkg::TagW-1:0] tag_eff;
  logic       match_eff, start_now;

  logic       rd_ok_q, rd_dir_q;
  logic [7:0] sess_rd_q, dir_rd_q;

  assign pop_o = valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    fill_d    = fill_q;
    tag_d     = tag_q;
    match_d   = match_q;
    good_d    = good_q;
    bad_d     = bad_q;
    err_d     = err_q;
    total_d   = total_q;
    notify_d  = notify_q;
    status_d  = fsr_pkg::ST_ACCEPTED;
    we_sess   = 1'b0;
    we_dir    = 1'b0;
    start_now = cmd_i.first && cmd_i.start;
    tag_eff   = start_now ? cmd_i.tag : tag_q;
    fill_eff  = start_now ? 10'd0 : fill_q;
    match_eff = cmd_i.first ? (cmd_i.tag == tag_eff) : match_q;
    pos       = fill_eff + {2'b00, cmd_i.offset};
    grown     = fill_eff + {2'b00, cmd_i.frag_len};
    unique case (cmd_i.kind)
      fsr_pkg::KIND_READ: begin
        status_d = fsr_pkg::ST_READ_DATA;
      end
      fsr_pkg::KIND_DIRECT: begin
        we_dir = cmd_i.below_len && ({2'b00, cmd_i.offset} < RecW);
        if (cmd_i.last) begin
          good_d   = good_q + 32'd1;
          total_d  = total_q + 32'd1;
          notify_d = notify_q + 32'd1;
          status_d = fsr_pkg::ST_DIRECT_DONE;
        end
      end
      fsr_pkg::KIND_SESSION: begin
        tag_d   = tag_eff;
        fill_d  = fill_eff;
        match_d = match_eff;
        if (match_eff) begin
          we_sess = cmd_i.below_len && (pos < RecW);
          if (cmd_i.last) begin
            if (grown >= RecW) begin
              total_d = total_q + 32'd1;
              if (grown == RecW) begin
                good_d   = good_q + 32'd1;
                notify_d = notify_q + 32'd1;
                status_d = fsr_pkg::ST_SESS_DONE;
              end else begin
                err_d    = err_q + 32'd1;
                bad_d    = bad_q + 32'd1;
                status_d = fsr_pkg::ST_OVERRUN;
              end
              tag_d  = '0;
              fill_d = 10'd0;
            end else begin
              fill_d = grown;
            end
          end
        end else begin
          status_d = fsr_pkg::ST_MISMATCH;
          if (cmd_i.last) begin
            err_d   = err_q + 32'd1;
            bad_d   = bad_q + 32'd1;
            total_d = total_q + 32'd1;
            tag_d   = '0;
            fill_d  = 10'd0;
          end
        end
      end
      default: begin
        status_d = fsr_pkg::ST_ACCEPTED;
      end
    endcase
  end

  // Stores: each popped transaction reads both stores and may write one
  always_ff @(posedge clk_i) begin
    if (pop_o && we_sess) begin
      sess_mem[pos[AddrW-1:0]] <= cmd_i.data;
    end
    if (pop_o) begin
      sess_rd_q <= sess_mem[cmd_i.read_index[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && we_dir) begin
      dir_mem[cmd_i.offset[AddrW-1:0]] <= cmd_i.data;
    end
    if (pop_o) begin
      dir_rd_q <= dir_mem[cmd_i.read_index[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_ok_q  <= (cmd_i.kind == fsr_pkg::KIND_READ) &&
                  ({2'b00, cmd_i.read_index} < RecW);
      rd_dir_q <= cmd_i.read_direct;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      fill_q      <= 10'd0;
      tag_q       <= '0;
      match_q     <= 1'b0;
      good_q      <= 32'd0;
      bad_q       <= 32'd0;
      err_q       <= 32'd0;
      total_q     <= 32'd0;
      notify_q    <= 32'd0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        fill_q      <= fill_d;
        tag_q       <= tag_d;
        match_q     <= match_d;
        good_q      <= good_d;
        bad_q       <= bad_d;
        err_q       <= err_d;
        total_q     <= total_d;
        notify_q    <= notify_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Counters only move on a pop, so they always match the result on display
  assign out_valid_o             = out_valid_q;
  assign out_item_o.status       = status_q;
  assign out_item_o.read_data    = rd_ok_q ? (rd_dir_q ? dir_rd_q : sess_rd_q) : 8'd0;
  assign out_item_o.good_count   = good_q;
  assign out_item_o.bad_count    = bad_q;
  assign out_item_o.error_count  = err_q;
  assign out_item_o.total_count  = total_q;
  assign out_item_o.notify_count = notify_q;

endmodule

### rtl/fragment_session_reassembler.sv
// Fragment session reassembler.
// Input channel: in_valid_i / in_stall_o carry one transaction per byte of a
//   transport fragment, or a one-byte read of the session or direct store.
// Output channel: out_valid_o / out_stall_i carry exactly one result per
//   input transaction, in order: status, read byte and the five counters
//   as they stand after that transaction.
// Each accepted transaction is queued; the back end registers its result.
// Throughput: one transaction per cycle unless out_stall_i holds a result;
//   each one reads both stores in the back end and may write one of them.
// The front end tracks the byte position inside the fragment and classifies
//   the transaction; a two-entry queue decouples it from the back end, which
//   owns the session state, counters and both 8-bit stores.
// Receiver stall: the result holds; the queue keeps taking transactions
//   until both entries are in use, then in_stall_o rises.
// Reset: counters, fill count, session tag and fragment position clear at
//   once; the stores are not cleared and read undefined until written.
module fragment_session_reassembler #(
  parameter int unsigned RECORD_BYTES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fsr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fsr_pkg::out_item_t out_item_o
);

  logic          push, full, pop, q_valid;
  fsr_pkg::cmd_t push_cmd, head_cmd;

  // stall only when the queue is full
  assign in_stall_o = full;

  fsr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_item_i (in_item_i),
    .full_i    (full),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  fsr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .cmd_o  (head_cmd)
  );

  fsr_back #(
    .RECORD_BYTES(RECORD_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .cmd_i      (head_cmd),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

### rtl/fsr_checker.sv
module fsr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input fsr_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input fsr_pkg::out_item_t out_item_o
);

  // stalled input transaction holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("stalled input changed");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // read byte only on read results
  a_rdata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != fsr_pkg::ST_READ_DATA)
      |-> out_item_o.read_data == 8'd0)
    else $error("read_data set on non-read result");

  // every good exchange raises a notify
  a_good_notify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.good_count == out_item_o.notify_count)
    else $error("good and notify counts diverged");

  // every finished exchange is either good or bad, each bad one is an error
  a_total_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.total_count ==
                     32'(out_item_o.good_count + out_item_o.bad_count)) &&
                    (out_item_o.error_count == out_item_o.bad_count))
    else $error("counter totals inconsistent");

endmodule

bind fragment_session_reassembler fsr_checker u_fsr_checker (.*);

### bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Record size the DUT is built with; the predictor clips at the same size.
  localparam int unsigned RecordBytes = 256;

  // Two copies of the predictor state: one advanced while the stimulus is
  // built (tells which store bytes exist, so reads only hit written bytes),
  // one advanced on every transaction the DUT accepts (scoreboard side).
  localparam int Plan  = 0;
  localparam int Score = 1;

  localparam int unsigned ItemTarget  = 450;
  localparam int unsigned CycleLimit  = 200_000; // well above worst-case stalls
  localparam int unsigned QuietTail   = 80;      // last items go without idling
  localparam int unsigned HoldAfter   = 150;     // accepted count that starts long hold
  localparam int unsigned HoldCycles  = 90;
  localparam int unsigned DrainCycles = 20;      // plenty of slack for the last results
  localparam int unsigned ShownFails  = 10;

  typedef struct packed {
    logic              drain;  // wait for all results before offering this one
    fsr_pkg::in_item_t item;
  } send_t;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  fsr_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  fsr_pkg::out_item_t out_item;

  fragment_session_reassembler #(
    .RECORD_BYTES(RecordBytes)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  initial forever #2 clk_i = ~clk_i;

  send_t              items_to_send[$];
  fsr_pkg::out_item_t results_due[$];
  bit          drain_next;
  bit          in_took;
  bit          hold_done;
  int unsigned in_count;
  int unsigned out_count;
  int unsigned cycles;
  int unsigned failures;
  int unsigned tx_gap;
  int unsigned rx_gap;
  int unsigned rx_hold;

  // ---------------------------------------------------------------------
  // Reassembly predictor state, indexed by copy (Plan / Score)
  // ---------------------------------------------------------------------
  logic [7:0] sess_mem   [2][256];
  logic [7:0] direct_mem [2][256];
  bit         sess_wr    [2][256];
  bit         direct_wr  [2][256];
  bit [9:0]   fill       [2];
  bit [3:0]   cur_tag    [2];
  bit [7:0]   frag_pos   [2];
  bit         tag_ok     [2];
  bit [31:0]  n_good     [2];
  bit [31:0]  n_bad      [2];
  bit [31:0]  n_err      [2];
  bit [31:0]  n_total    [2];
  bit [31:0]  n_notify   [2];

  function automatic void close_session(int c);
    cur_tag[c] = '0;
    fill[c]    = '0;
  endfunction

  // Advances copy c by one transaction and returns the result it must give.
  function automatic fsr_pkg::out_item_t reassemble(int c, fsr_pkg::in_item_t it);
    fsr_pkg::out_item_t res;
    bit [9:0]  wpos;
    bit [9:0]  grown;
    res.status    = fsr_pkg::ST_ACCEPTED;
    res.read_data = '0;
    if (it.req_type) begin
      res.status = fsr_pkg::ST_READ_DATA;
      if (it.read_index < RecordBytes)
        res.read_data = it.read_direct ? direct_mem[c][it.read_index]
                                       : sess_mem[c][it.read_index];
    end else begin
      if (it.first_byte) frag_pos[c] = '0;
      if (it.direct_mode) begin
        // direct copy always starts at byte 0 of the record
        if (frag_pos[c] < it.frag_len && frag_pos[c] < RecordBytes) begin
          direct_mem[c][frag_pos[c]] = it.data_byte;
          direct_wr[c][frag_pos[c]]  = 1'b1;
        end
        if (it.last_byte) begin
          n_good[c]++;
          n_total[c]++;
          n_notify[c]++;
          res.status = fsr_pkg::ST_DIRECT_DONE;
        end
      end else begin
        // tag is taken / compared on the first transaction only
        if (it.first_byte) begin
          if (it.start_session) begin
            cur_tag[c] = it.session_byte[7:4];
            fill[c]    = '0;
          end
          tag_ok[c] = (it.session_byte[7:4] == cur_tag[c]);
        end
        if (tag_ok[c]) begin
          wpos = fill[c] + frag_pos[c];
          if (frag_pos[c] < it.frag_len && wpos < RecordBytes) begin
            sess_mem[c][wpos[7:0]] = it.data_byte;
            sess_wr[c][wpos[7:0]]  = 1'b1;
          end
          if (it.last_byte) begin
            // fill grows by the stated length, not by bytes seen
            grown = fill[c] + it.frag_len;
            if (grown >= RecordBytes) begin
              n_total[c]++;
              if (grown == RecordBytes) begin
                n_good[c]++;
                n_notify[c]++;
                res.status = fsr_pkg::ST_SESS_DONE;
              end else begin
                n_err[c]++;
                n_bad[c]++;
                res.status = fsr_pkg::ST_OVERRUN;
              end
              close_session(c);
            end else begin
              fill[c] = grown;
            end
          end
        end else begin
          res.status = fsr_pkg::ST_MISMATCH;
          if (it.last_byte) begin
            n_err[c]++;
            n_bad[c]++;
            n_total[c]++;
            close_session(c);
          end
        end
      end
      if (frag_pos[c] != 8'hFF) frag_pos[c]++;
    end
    res.good_count   = n_good[c];
    res.bad_count    = n_bad[c];
    res.error_count  = n_err[c];
    res.total_count  = n_total[c];
    res.notify_count = n_notify[c];
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------
  function automatic fsr_pkg::in_item_t rand_bits();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(fsr_pkg::in_item_t)-1:0];
  endfunction

  task automatic push_item(fsr_pkg::in_item_t it);
    void'(reassemble(Plan, it));
    items_to_send.push_back({drain_next, it});
    drain_next = 1'b0;
  endtask

  // Item count for a fragment of stated length len: exact for short ones,
  // sometimes running past the length, cut short when the length is large.
  function automatic int frag_items(logic [7:0] len);
    if (len == 0) return 1;
    if (len > 10) return $urandom_range(1, 6);
    if ($urandom_range(0, 5) == 0) return len + $urandom_range(1, 2);
    return len;
  endfunction

  // One fragment of n transactions; edges alternates payload 00 / FF.
  task automatic frag(bit dm, bit st, logic [7:0] sb, logic [7:0] len, int n, bit edges);
    fsr_pkg::in_item_t it;
    for (int i = 0; i < n; i++) begin
      it             = rand_bits();
      it.req_type    = 1'b0;
      it.direct_mode = dm;
      it.frag_len    = len;
      it.first_byte  = (i == 0);
      it.last_byte   = (i == n - 1);
      if (i == 0) begin
        it.start_session = st;
        it.session_byte  = sb;
      end
      if (edges) it.data_byte = (i % 2 == 0) ? 8'h00 : 8'hFF;
      push_item(it);
    end
  endtask

  task automatic read_at(bit dir, logic [7:0] idx);
    fsr_pkg::in_item_t it;
    it             = rand_bits();
    it.req_type    = 1'b1;
    it.read_direct = dir;
    it.read_index  = idx;
    push_item(it);
  endtask

  // Read a byte that has already been written in one of the stores.
  task automatic read_back();
    int unsigned hits[$];
    bit          dir;
    dir = 1'($urandom_range(0, 1));
    for (int pass = 0; pass < 2 && hits.size() == 0; pass++) begin
      if (pass == 1) dir = !dir;
      for (int i = 0; i < 256; i++)
        if (dir ? direct_wr[Plan][i] : sess_wr[Plan][i]) hits.push_back(i);
    end
    if (hits.size() != 0) read_at(dir, 8'(hits[$urandom_range(0, hits.size() - 1)]));
  endtask

  task automatic direct_run();
    logic [7:0] len;
    len = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 10));
    frag(1'b1, 1'($urandom), 8'($urandom), len, frag_items(len), 1'b0);
  endtask

  // A session exchange: ends exact, overruns, meets a foreign tag or is
  // abandoned; reads and direct fragments may slip in between fragments.
  task automatic session_run();
    logic [3:0] tag;
    logic [7:0] len;
    int         left;
    int         ending;
    bit         opening;
    tag     = 4'($urandom);
    ending  = $urandom_range(0, 3);
    left    = RecordBytes;
    opening = 1'b1;
    while (left > 0) begin
      if (!opening && ending == 2 && $urandom_range(0, 2) == 0) begin
        len = 8'($urandom);
        frag(1'b0, 1'b0, {tag ^ 4'($urandom_range(1, 15)), 4'($urandom)}, len,
             frag_items(len), 1'b0);
        return;
      end
      if (!opening && ending == 3 && $urandom_range(0, 3) == 0) return;
      if (ending == 1 && left <= 254) begin
        len  = 8'($urandom_range(left + 1, 255));
        left = 0;
      end else begin
        len  = 8'($urandom_range(1, (left > 255) ? 255 : left));
        left = left - len;
      end
      frag(1'b0, opening, {tag, 4'($urandom)}, len, frag_items(len), 1'b0);
      opening = 1'b0;
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 1) == 0) read_back();
        else direct_run();
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Sender: presents transactions at the falling edge, holds on stall
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin : drive
    logic              nxt_valid;
    fsr_pkg::in_item_t nxt_item;
    send_t             nxt_send;
    nxt_valid = 1'b0;
    nxt_item  = in_item;
    if (rst_ni && !(in_valid && !in_took)) begin
      if (tx_gap != 0) begin
        tx_gap--;
      end else if (items_to_send.size() != 0) begin
        if (items_to_send[0].drain && results_due.size() != 0) begin
          // paused until the DUT has handed back everything in flight
        end else if (items_to_send.size() >= QuietTail && rx_hold == 0 &&
                     $urandom_range(0, 9) == 0) begin
          tx_gap = $urandom_range(1, 14) - 1;
        end else begin
          nxt_valid = 1'b1;
          nxt_send  = items_to_send.pop_front();
          nxt_item  = nxt_send.item;
        end
      end
      in_valid <= nxt_valid;
      in_item  <= nxt_item;
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts plus one long hold that backs the DUT up
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin : receive
    logic nxt_stall;
    if (!hold_done && in_count >= HoldAfter) begin
      hold_done = 1'b1;
      rx_hold   = HoldCycles;
    end
    if (rx_hold != 0) begin
      nxt_stall = 1'b1;
      rx_hold--;
    end else if (rx_gap != 0) begin
      nxt_stall = 1'b1;
      rx_gap--;
    end else if (items_to_send.size() >= QuietTail && $urandom_range(0, 7) == 0) begin
      nxt_stall = 1'b1;
      rx_gap    = $urandom_range(1, 14) - 1;
    end else begin
      nxt_stall = 1'b0;
    end
    out_stall <= nxt_stall;
  end

  // ---------------------------------------------------------------------
  // Monitor: predicts on each accepted transaction, checks results in order
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    fsr_pkg::out_item_t want;
    cycles++;
    in_took = rst_ni && in_valid && !in_stall;
    if (in_took) begin
      results_due.push_back(reassemble(Score, in_item));
      in_count++;
    end
    if (rst_ni && out_valid && !out_stall) begin
      out_count++;
      if (results_due.size() == 0) begin
        failures++;
        if (failures <= ShownFails)
          $display("result %0d arrived with nothing expected: status %0d data %02h",
                   out_count, out_item.status, out_item.read_data);
      end else begin
        want = results_due.pop_front();
        if (out_item.status       !== want.status       ||
            out_item.read_data    !== want.read_data    ||
            out_item.good_count   !== want.good_count   ||
            out_item.bad_count    !== want.bad_count    ||
            out_item.error_count  !== want.error_count  ||
            out_item.total_count  !== want.total_count  ||
            out_item.notify_count !== want.notify_count) begin
          failures++;
          if (failures <= ShownFails) begin
            $display("result %0d exp: status %0d data %02h good %0d bad %0d err %0d tot %0d ntf %0d",
                     out_count, want.status, want.read_data, want.good_count,
                     want.bad_count, want.error_count, want.total_count,
                     want.notify_count);
            $display("result %0d got: status %0d data %02h good %0d bad %0d err %0d tot %0d ntf %0d",
                     out_count, out_item.status, out_item.read_data, out_item.good_count,
                     out_item.bad_count, out_item.error_count, out_item.total_count,
                     out_item.notify_count);
          end
        end
      end
    end
    if (cycles >= CycleLimit) begin
      $display("fragment_session_reassembler verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------
  initial begin : run
    fsr_pkg::in_item_t it;
    int                pick;

    // Directed: zero-length direct fragment, direct bytes 00/FF, bytes past
    // the stated length, readback of the direct store at index 0 and 2
    frag(1'b1, 1'b0, 8'h00, 8'd0, 1, 1'b0);
    frag(1'b1, 1'b1, 8'hFF, 8'd3, 3, 1'b1);
    frag(1'b1, 1'b0, 8'h00, 8'd1, 3, 1'b1);
    read_at(1'b1, 8'd0);
    read_at(1'b1, 8'd2);
    // open tag F, then a foreign tag: mismatch on every transaction, clear
    frag(1'b0, 1'b1, 8'hF0, 8'd2, 2, 1'b1);
    frag(1'b0, 1'b0, 8'h3C, 8'd1, 2, 1'b0);
    // tag 0: stated 255 then 1 lands exactly on the record size
    frag(1'b0, 1'b1, 8'h0F, 8'd255, 1, 1'b1);
    frag(1'b0, 1'b0, 8'h01, 8'd1, 1, 1'b1);
    read_at(1'b0, 8'd255);
    read_at(1'b0, 8'd0);
    // 200 + 200 passes the record: overrun
    frag(1'b0, 1'b1, 8'h5A, 8'd200, 1, 1'b0);
    frag(1'b0, 1'b0, 8'h55, 8'd200, 1, 1'b0);
    // zero-length session fragment, then a transaction with no first mark
    frag(1'b0, 1'b1, 8'h1E, 8'd0, 1, 1'b0);
    it             = rand_bits();
    it.req_type    = 1'b0;
    it.direct_mode = 1'b0;
    it.first_byte  = 1'b0;
    it.last_byte   = 1'b1;
    it.frag_len    = 8'd3;
    push_item(it);

    // One long fragment after a full drain: offset saturates and session bytes
    // 0 to 254 get written, then one byte completes the record.
    drain_next = 1'b1;
    it.session_byte = 8'($urandom);
    frag(1'b0, 1'b1, it.session_byte, 8'd255, 258, 1'b0);
    frag(1'b0, 1'b0, {it.session_byte[7:4], 4'($urandom)}, 8'd1, 1, 1'b0);

    while (items_to_send.size() < ItemTarget) begin
      pick = $urandom_range(0, 19);
      if ($urandom_range(0, 39) == 0) drain_next = 1'b1;
      if (pick < 10) begin
        session_run();
      end else if (pick < 14) begin
        direct_run();
      end else if (pick < 18) begin
        read_back();
      end else begin
        it          = rand_bits();
        it.req_type = 1'b0;
        push_item(it);
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (items_to_send.size() != 0 || in_valid || results_due.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (results_due.size() != 0) begin
      failures += results_due.size();
      $display("%0d results never arrived", results_due.size());
    end
    if (failures == 0) begin
      $display("fragment_session_reassembler verification clean");
    end else begin
      $display("fragment_session_reassembler verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/fsr_pkg.sv
rtl/fsr_front.sv
rtl/fsr_queue.sv
rtl/fsr_back.sv
rtl/fragment_session_reassembler.sv
rtl/fsr_checker.sv
bench/tb_top.sv
